// ===== hw/rtl/tcc_pkg.sv =====
// Shared widths, types and the divider step for the triangle circumcircle block.
package tcc_pkg;

  localparam int COORD_W = 24;                  // corner coordinate width
  localparam int DIF_W   = COORD_W + 1;         // corner difference
  localparam int PROD_W  = 2 * DIF_W;           // product of two differences
  localparam int DET_W   = PROD_W + 1;          // cross product
  localparam int LEN_W   = 2 * COORD_W + 1;     // squared edge length, unsigned
  localparam int LO_W    = DIF_W;               // low slice of a squared length
  localparam int PP_W    = DIF_W + LO_W + 1;    // partial product
  localparam int NUM_W   = DIF_W + LEN_W + 1;   // center numerator, signed
  localparam int NSUM_W  = NUM_W + 1;           // |num| + |det|
  localparam int DIV_W   = DET_W + 1;           // divisor 2*|det|
  localparam int QB      = 42;                  // quotient bits kept
  localparam int DIV_ST  = QB / 2;              // two quotient bits per stage
  localparam int MAG_W   = 41;                  // clipped offset magnitude
  localparam int OFF_W   = MAG_W + 1;           // signed offset
  localparam int SUM_W   = OFF_W + 1;           // corner plus offset
  localparam int OUT_W   = 32;                  // center output width
  localparam int DLT_W   = OUT_W + 1;           // corner minus center
  localparam int SQ_W    = 2 * OUT_W;           // squared delta
  localparam int RAD_W   = 63;                  // radius output width

  localparam logic [MAG_W-1:0] MAG_LIM = MAG_W'(1) << (MAG_W - 1);

  typedef struct packed {
    logic signed [COORD_W-1:0] coord;
    logic                      neg;
    logic                      degen;
  } side_t;

  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic             qbit;
  } dstep_t;

  // one restoring division step
  function automatic dstep_t div_step(input logic [DIV_W-1:0] rem, input logic nb,
                                      input logic [DIV_W-1:0] dv);
    logic [DIV_W:0]   t;
    logic [DIV_W+1:0] s;
    dstep_t           o;
    t = {rem, nb};
    s = {1'b0, t} - {2'b00, dv};
    if (s[DIV_W+1]) begin
      o.rem  = t[DIV_W-1:0];
      o.qbit = 1'b0;
    end else begin
      o.rem  = s[DIV_W-1:0];
      o.qbit = 1'b1;
    end
    return o;
  endfunction

endpackage

// ===== hw/rtl/tcc_front.sv =====
// Front stages: edge differences, their products, cross product and squared lengths.
module tcc_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [tcc_pkg::COORD_W-1:0]  first_x_i,
  input  logic signed [tcc_pkg::COORD_W-1:0]  first_y_i,
  input  logic signed [tcc_pkg::COORD_W-1:0]  second_x_i,
  input  logic signed [tcc_pkg::COORD_W-1:0]  second_y_i,
  input  logic signed [tcc_pkg::COORD_W-1:0]  third_x_i,
  input  logic signed [tcc_pkg::COORD_W-1:0]  third_y_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [tcc_pkg::COORD_W-1:0]  x1_o,
  output logic signed [tcc_pkg::COORD_W-1:0]  y1_o,
  output logic signed [tcc_pkg::DIF_W-1:0]    ax_o,
  output logic signed [tcc_pkg::DIF_W-1:0]    ay_o,
  output logic signed [tcc_pkg::DIF_W-1:0]    bx_o,
  output logic signed [tcc_pkg::DIF_W-1:0]    by_o,
  output logic signed [tcc_pkg::DET_W-1:0]    det_o,
  output logic        [tcc_pkg::LEN_W-1:0]    la_o,
  output logic        [tcc_pkg::LEN_W-1:0]    lb_o
);
  import tcc_pkg::*;

  logic [2:0] v_q;
  logic [2:0] ld;

  assign ld[2] = !v_q[2] || out_ready_i;
  assign ld[1] = !v_q[1] || ld[2];
  assign ld[0] = !v_q[0] || ld[1];

  // stage 1: differences
  logic signed [COORD_W-1:0] x1_s1_q, y1_s1_q;
  logic signed [DIF_W-1:0]   ax_s1_q, ay_s1_q, bx_s1_q, by_s1_q;
  logic signed [DIF_W-1:0]   ax_d, ay_d, bx_d, by_d;

  assign ax_d = DIF_W'(second_x_i) - DIF_W'(first_x_i);
  assign ay_d = DIF_W'(second_y_i) - DIF_W'(first_y_i);
  assign bx_d = DIF_W'(third_x_i) - DIF_W'(first_x_i);
  assign by_d = DIF_W'(third_y_i) - DIF_W'(first_y_i);

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      x1_s1_q <= first_x_i;
      y1_s1_q <= first_y_i;
      ax_s1_q <= ax_d;
      ay_s1_q <= ay_d;
      bx_s1_q <= bx_d;
      by_s1_q <= by_d;
    end
  end

  // stage 2: products
  logic signed [COORD_W-1:0] x1_s2_q, y1_s2_q;
  logic signed [DIF_W-1:0]   ax_s2_q, ay_s2_q, bx_s2_q, by_s2_q;
  logic signed [PROD_W-1:0]  axby_q, aybx_q, axax_q, ayay_q, bxbx_q, byby_q;

  always_ff @(posedge clk_i) begin
    if (ld[1]) begin
      x1_s2_q <= x1_s1_q;
      y1_s2_q <= y1_s1_q;
      ax_s2_q <= ax_s1_q;
      ay_s2_q <= ay_s1_q;
      bx_s2_q <= bx_s1_q;
      by_s2_q <= by_s1_q;
      axby_q  <= ax_s1_q * by_s1_q;
      aybx_q  <= ay_s1_q * bx_s1_q;
      axax_q  <= ax_s1_q * ax_s1_q;
      ayay_q  <= ay_s1_q * ay_s1_q;
      bxbx_q  <= bx_s1_q * bx_s1_q;
      byby_q  <= by_s1_q * by_s1_q;
    end
  end

  // stage 3: cross product and squared lengths
  logic signed [DET_W-1:0] det_d, det_q;
  logic [LEN_W-1:0]        la_d, lb_d, la_q, lb_q;
  logic signed [COORD_W-1:0] x1_s3_q, y1_s3_q;
  logic signed [DIF_W-1:0]   ax_s3_q, ay_s3_q, bx_s3_q, by_s3_q;

  assign det_d = DET_W'(axby_q) - DET_W'(aybx_q);
  assign la_d  = LEN_W'(axax_q) + LEN_W'(ayay_q);
  assign lb_d  = LEN_W'(bxbx_q) + LEN_W'(byby_q);

  always_ff @(posedge clk_i) begin
    if (ld[2]) begin
      x1_s3_q <= x1_s2_q;
      y1_s3_q <= y1_s2_q;
      ax_s3_q <= ax_s2_q;
      ay_s3_q <= ay_s2_q;
      bx_s3_q <= bx_s2_q;
      by_s3_q <= by_s2_q;
      det_q   <= det_d;
      la_q    <= la_d;
      lb_q    <= lb_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (ld[0]) v_q[0] <= in_valid_i;
      if (ld[1]) v_q[1] <= v_q[0];
      if (ld[2]) v_q[2] <= v_q[1];
    end
  end

  assign in_ready_o  = ld[0];
  assign out_valid_o = v_q[2];
  assign x1_o  = x1_s3_q;
  assign y1_o  = y1_s3_q;
  assign ax_o  = ax_s3_q;
  assign ay_o  = ay_s3_q;
  assign bx_o  = bx_s3_q;
  assign by_o  = by_s3_q;
  assign det_o = det_q;
  assign la_o  = la_q;
  assign lb_o  = lb_q;

endmodule

// ===== hw/rtl/tcc_numer.sv =====
// Numerator stages: split products, center numerators, magnitudes and signs.
module tcc_numer (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [tcc_pkg::COORD_W-1:0] x1_i,
  input  logic signed [tcc_pkg::COORD_W-1:0] y1_i,
  input  logic signed [tcc_pkg::DIF_W-1:0]   ax_i,
  input  logic signed [tcc_pkg::DIF_W-1:0]   ay_i,
  input  logic signed [tcc_pkg::DIF_W-1:0]   bx_i,
  input  logic signed [tcc_pkg::DIF_W-1:0]   by_i,
  input  logic signed [tcc_pkg::DET_W-1:0]   det_i,
  input  logic        [tcc_pkg::LEN_W-1:0]   la_i,
  input  logic        [tcc_pkg::LEN_W-1:0]   lb_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [tcc_pkg::COORD_W-1:0] x1_o,
  output logic signed [tcc_pkg::COORD_W-1:0] y1_o,
  output logic        [tcc_pkg::NUM_W-1:0]   numx_o,
  output logic        [tcc_pkg::NUM_W-1:0]   numy_o,
  output logic        [tcc_pkg::DET_W-1:0]   den_o,
  output logic                               negx_o,
  output logic                               negy_o,
  output logic                               degen_o
);
  import tcc_pkg::*;

  logic [2:0] v_q;
  logic [2:0] ld;

  assign ld[2] = !v_q[2] || out_ready_i;
  assign ld[1] = !v_q[1] || ld[2];
  assign ld[0] = !v_q[0] || ld[1];

  // stage 4: squared lengths split in two slices, eight partial products
  logic signed [LO_W:0]          la_lo, lb_lo;
  logic signed [LEN_W-LO_W:0]    la_hi, lb_hi;
  logic signed [PP_W-1:0] pbl_q, pbh_q, pal_q, pah_q, pxl_q, pxh_q, pcl_q, pch_q;
  logic signed [COORD_W-1:0] x1_s4_q, y1_s4_q;
  logic signed [DET_W-1:0]   det_s4_q;

  assign la_lo = $signed({1'b0, la_i[LO_W-1:0]});
  assign lb_lo = $signed({1'b0, lb_i[LO_W-1:0]});
  assign la_hi = $signed({1'b0, la_i[LEN_W-1:LO_W]});
  assign lb_hi = $signed({1'b0, lb_i[LEN_W-1:LO_W]});

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      pbl_q    <= by_i * la_lo;
      pbh_q    <= by_i * la_hi;
      pal_q    <= ay_i * lb_lo;
      pah_q    <= ay_i * lb_hi;
      pxl_q    <= ax_i * lb_lo;
      pxh_q    <= ax_i * lb_hi;
      pcl_q    <= bx_i * la_lo;
      pch_q    <= bx_i * la_hi;
      x1_s4_q  <= x1_i;
      y1_s4_q  <= y1_i;
      det_s4_q <= det_i;
    end
  end

  // stage 5: nx = by*la - ay*lb, ny = ax*lb - bx*la
  logic signed [NUM_W-1:0] nx_d, ny_d, nx_q, ny_q;
  logic signed [COORD_W-1:0] x1_s5_q, y1_s5_q;
  logic signed [DET_W-1:0]   det_s5_q;

  assign nx_d = (NUM_W'(pbh_q) <<< LO_W) + NUM_W'(pbl_q)
              - (NUM_W'(pah_q) <<< LO_W) - NUM_W'(pal_q);
  assign ny_d = (NUM_W'(pxh_q) <<< LO_W) + NUM_W'(pxl_q)
              - (NUM_W'(pch_q) <<< LO_W) - NUM_W'(pcl_q);

  always_ff @(posedge clk_i) begin
    if (ld[1]) begin
      nx_q     <= nx_d;
      ny_q     <= ny_d;
      x1_s5_q  <= x1_s4_q;
      y1_s5_q  <= y1_s4_q;
      det_s5_q <= det_s4_q;
    end
  end

  // stage 6: magnitudes, quotient signs, collinear check
  logic [NUM_W-1:0] anx_q, any_q;
  logic [DET_W-1:0] ad_q;
  logic             negx_q, negy_q, degen_q;
  logic signed [COORD_W-1:0] x1_s6_q, y1_s6_q;

  always_ff @(posedge clk_i) begin
    if (ld[2]) begin
      anx_q   <= nx_q[NUM_W-1] ? NUM_W'(-nx_q) : NUM_W'(nx_q);
      any_q   <= ny_q[NUM_W-1] ? NUM_W'(-ny_q) : NUM_W'(ny_q);
      ad_q    <= det_s5_q[DET_W-1] ? DET_W'(-det_s5_q) : DET_W'(det_s5_q);
      negx_q  <= nx_q[NUM_W-1] ^ det_s5_q[DET_W-1];
      negy_q  <= ny_q[NUM_W-1] ^ det_s5_q[DET_W-1];
      degen_q <= (det_s5_q == '0);
      x1_s6_q <= x1_s5_q;
      y1_s6_q <= y1_s5_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (ld[0]) v_q[0] <= in_valid_i;
      if (ld[1]) v_q[1] <= v_q[0];
      if (ld[2]) v_q[2] <= v_q[1];
    end
  end

  assign in_ready_o  = ld[0];
  assign out_valid_o = v_q[2];
  assign x1_o    = x1_s6_q;
  assign y1_o    = y1_s6_q;
  assign numx_o  = anx_q;
  assign numy_o  = any_q;
  assign den_o   = ad_q;
  assign negx_o  = negx_q;
  assign negy_o  = negy_q;
  assign degen_o = degen_q;

endmodule

// ===== hw/rtl/tcc_div.sv =====
// Pipelined restoring divider: (num + den) / (2*den), two quotient bits per stage.
module tcc_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [tcc_pkg::NUM_W-1:0]       num_i,
  input  logic [tcc_pkg::DET_W-1:0]       den_i,
  input  tcc_pkg::side_t                  side_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [tcc_pkg::QB-1:0]          quot_o,
  output logic                            ovf_o,
  output tcc_pkg::side_t                  side_o
);
  import tcc_pkg::*;

  logic [DIV_ST:0] v_q;
  logic [DIV_ST:0] ld;

  logic [DIV_W-1:0] rem_q  [DIV_ST];
  logic [QB-1:0]    nl_q   [DIV_ST];
  logic [DIV_W-1:0] dd_q   [DIV_ST];
  logic [QB-1:0]    qt_q   [DIV_ST+1];
  logic             ovf_q  [DIV_ST+1];
  side_t            side_q [DIV_ST+1];

  // enable chain: a stage loads when empty or when the next one moves
  for (genvar k = 0; k <= DIV_ST; k++) begin : g_ld
    if (k == DIV_ST) begin : g_last
      assign ld[k] = !v_q[k] || out_ready_i;
    end else begin : g_mid
      assign ld[k] = !v_q[k] || ld[k+1];
    end
  end

  // entry: dividend and divisor, early overflow when quotient needs more than QB bits
  logic [NSUM_W-1:0]    nsum_d;
  logic [DIV_W-1:0]     dd_d;
  logic [NSUM_W-QB-1:0] top_d;

  assign nsum_d = NSUM_W'(num_i) + NSUM_W'(den_i);
  assign dd_d   = {den_i, 1'b0};
  assign top_d  = nsum_d[NSUM_W-1:QB];

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      rem_q[0]  <= DIV_W'(top_d);
      nl_q[0]   <= nsum_d[QB-1:0];
      dd_q[0]   <= dd_d;
      qt_q[0]   <= '0;
      ovf_q[0]  <= (DIV_W'(top_d) >= dd_d);
      side_q[0] <= side_i;
    end
  end

  for (genvar k = 1; k <= DIV_ST; k++) begin : g_st
    dstep_t s_hi, s_lo;

    always_comb begin
      s_hi = div_step(rem_q[k-1], nl_q[k-1][QB-1], dd_q[k-1]);
      s_lo = div_step(s_hi.rem, nl_q[k-1][QB-2], dd_q[k-1]);
    end

    always_ff @(posedge clk_i) begin
      if (ld[k]) begin
        qt_q[k]   <= {qt_q[k-1][QB-3:0], s_hi.qbit, s_lo.qbit};
        ovf_q[k]  <= ovf_q[k-1];
        side_q[k] <= side_q[k-1];
      end
    end

    if (k < DIV_ST) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (ld[k]) begin
          rem_q[k] <= s_lo.rem;
          nl_q[k]  <= nl_q[k-1] << 2;
          dd_q[k]  <= dd_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (ld[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k <= DIV_ST; k++) begin
        if (ld[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign in_ready_o  = ld[0];
  assign out_valid_o = v_q[DIV_ST];
  assign quot_o      = qt_q[DIV_ST];
  assign ovf_o       = ovf_q[DIV_ST];
  assign side_o      = side_q[DIV_ST];

endmodule

// ===== hw/rtl/triangle_circumcircle.sv =====
// A triangle passes 33 register stages from input acceptance to result:
//   3 front, 3 numerator, 22 divider and 5 output stages.
// Throughput: one triangle per cycle while out_stall_i is low; every stage
//   has its own valid bit and load enable.
// The two 42-bit quotients come from two pipelined dividers, 2 bits per stage.
// Reset clears all valid bits; data registers are not reset.
module triangle_circumcircle (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [tcc_pkg::COORD_W-1:0] first_x_i,
  input  logic signed [tcc_pkg::COORD_W-1:0] first_y_i,
  input  logic signed [tcc_pkg::COORD_W-1:0] second_x_i,
  input  logic signed [tcc_pkg::COORD_W-1:0] second_y_i,
  input  logic signed [tcc_pkg::COORD_W-1:0] third_x_i,
  input  logic signed [tcc_pkg::COORD_W-1:0] third_y_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [tcc_pkg::OUT_W-1:0]   center_x_o,
  output logic signed [tcc_pkg::OUT_W-1:0]   center_y_o,
  output logic        [tcc_pkg::RAD_W-1:0]   radius_squared_o,
  output logic                               degenerate_o,
  output logic                               saturated_o
);
  import tcc_pkg::*;

  // ---------------------------------------------------------------
  // Front: a = second - first, b = third - first, det = a x b,
  // la = |a|^2, lb = |b|^2.
  // ---------------------------------------------------------------
  logic                      fr_valid, fr_ready;
  logic signed [COORD_W-1:0] fr_x1, fr_y1;
  logic signed [DIF_W-1:0]   fr_ax, fr_ay, fr_bx, fr_by;
  logic signed [DET_W-1:0]   fr_det;
  logic [LEN_W-1:0]          fr_la, fr_lb;
  logic                      front_ready;

  tcc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (front_ready),
    .first_x_i   (first_x_i),
    .first_y_i   (first_y_i),
    .second_x_i  (second_x_i),
    .second_y_i  (second_y_i),
    .third_x_i   (third_x_i),
    .third_y_i   (third_y_i),
    .out_valid_o (fr_valid),
    .out_ready_i (fr_ready),
    .x1_o        (fr_x1),
    .y1_o        (fr_y1),
    .ax_o        (fr_ax),
    .ay_o        (fr_ay),
    .bx_o        (fr_bx),
    .by_o        (fr_by),
    .det_o       (fr_det),
    .la_o        (fr_la),
    .lb_o        (fr_lb)
  );

  assign in_stall_o = !front_ready;

  // ---------------------------------------------------------------
  // Numerators: nx = by*la - ay*lb, ny = ax*lb - bx*la; magnitudes and
  // quotient signs for the dividers.
  // ---------------------------------------------------------------
  logic                      nu_valid, nu_ready;
  logic signed [COORD_W-1:0] nu_x1, nu_y1;
  logic [NUM_W-1:0]          nu_numx, nu_numy;
  logic [DET_W-1:0]          nu_den;
  logic                      nu_negx, nu_negy, nu_degen;

  tcc_numer u_numer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fr_valid),
    .in_ready_o  (fr_ready),
    .x1_i        (fr_x1),
    .y1_i        (fr_y1),
    .ax_i        (fr_ax),
    .ay_i        (fr_ay),
    .bx_i        (fr_bx),
    .by_i        (fr_by),
    .det_i       (fr_det),
    .la_i        (fr_la),
    .lb_i        (fr_lb),
    .out_valid_o (nu_valid),
    .out_ready_i (nu_ready),
    .x1_o        (nu_x1),
    .y1_o        (nu_y1),
    .numx_o      (nu_numx),
    .numy_o      (nu_numy),
    .den_o       (nu_den),
    .negx_o      (nu_negx),
    .negy_o      (nu_negy),
    .degen_o     (nu_degen)
  );

  // ---------------------------------------------------------------
  // Dividers: round(|n| / (2|det|)) as floor((|n| + |det|) / (2|det|)).
  // Both run in lockstep; each carries its own corner coordinate.
  // ---------------------------------------------------------------
  side_t            sdx_in, sdy_in, sdx_out, sdy_out;
  logic             dvx_valid, dvy_valid, dvx_ready, dvy_ready;
  logic [QB-1:0]    qx, qy;
  logic             ovfx, ovfy;
  logic             dv_valid;
  logic             ld_a, ld_b, ld_c, ld_d, ld_e;

  assign sdx_in.coord = nu_x1;
  assign sdx_in.neg   = nu_negx;
  assign sdx_in.degen = nu_degen;
  assign sdy_in.coord = nu_y1;
  assign sdy_in.neg   = nu_negy;
  assign sdy_in.degen = nu_degen;

  tcc_div u_div_x (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (nu_valid),
    .in_ready_o  (dvx_ready),
    .num_i       (nu_numx),
    .den_i       (nu_den),
    .side_i      (sdx_in),
    .out_valid_o (dvx_valid),
    .out_ready_i (ld_a),
    .quot_o      (qx),
    .ovf_o       (ovfx),
    .side_o      (sdx_out)
  );

  tcc_div u_div_y (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (nu_valid),
    .in_ready_o  (dvy_ready),
    .num_i       (nu_numy),
    .den_i       (nu_den),
    .side_i      (sdy_in),
    .out_valid_o (dvy_valid),
    .out_ready_i (ld_a),
    .quot_o      (qy),
    .ovf_o       (ovfy),
    .side_o      (sdy_out)
  );

  assign nu_ready = dvx_ready && dvy_ready;
  assign dv_valid = dvx_valid && dvy_valid;

  // ---------------------------------------------------------------
  // Output stages A..E; E is the output register, so a waiting result
  // does not block items behind it while A..D have room.
  // ---------------------------------------------------------------
  logic v_a_q, v_b_q, v_c_q, v_d_q, v_e_q;

  assign ld_e = !v_e_q || !out_stall_i;
  assign ld_d = !v_d_q || ld_e;
  assign ld_c = !v_c_q || ld_d;
  assign ld_b = !v_b_q || ld_c;
  assign ld_a = !v_a_q || ld_b;

  // A: clip magnitude to 2^40 and apply sign
  logic [MAG_W-1:0]          magx_d, magy_d;
  logic signed [OFF_W-1:0]   offx_d, offy_d, offx_q, offy_q;
  logic signed [COORD_W-1:0] x1_a_q, y1_a_q;
  logic                      degen_a_q;

  assign magx_d = (ovfx || qx > QB'(MAG_LIM)) ? MAG_LIM : qx[MAG_W-1:0];
  assign magy_d = (ovfy || qy > QB'(MAG_LIM)) ? MAG_LIM : qy[MAG_W-1:0];
  assign offx_d = sdx_out.neg ? -$signed({1'b0, magx_d}) : $signed({1'b0, magx_d});
  assign offy_d = sdy_out.neg ? -$signed({1'b0, magy_d}) : $signed({1'b0, magy_d});

  always_ff @(posedge clk_i) begin
    if (ld_a) begin
      offx_q    <= offx_d;
      offy_q    <= offy_d;
      x1_a_q    <= sdx_out.coord;
      y1_a_q    <= sdy_out.coord;
      degen_a_q <= sdx_out.degen;
    end
  end

  // B: center = corner + offset, saturated to 32 bits
  logic signed [SUM_W-1:0]   sumx, sumy;
  logic                      posx, negx, posy, negy;
  logic signed [OUT_W-1:0]   cx_d, cy_d, cx_q, cy_q;
  logic signed [COORD_W-1:0] x1_b_q, y1_b_q;
  logic                      degen_b_q, satc_q;

  localparam logic signed [OUT_W-1:0] CMAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] CMIN = {1'b1, {(OUT_W-1){1'b0}}};

  assign sumx = SUM_W'(x1_a_q) + SUM_W'(offx_q);
  assign sumy = SUM_W'(y1_a_q) + SUM_W'(offy_q);
  assign posx = !sumx[SUM_W-1] && (|sumx[SUM_W-2:OUT_W-1]);
  assign negx = sumx[SUM_W-1] && !(&sumx[SUM_W-2:OUT_W-1]);
  assign posy = !sumy[SUM_W-1] && (|sumy[SUM_W-2:OUT_W-1]);
  assign negy = sumy[SUM_W-1] && !(&sumy[SUM_W-2:OUT_W-1]);
  assign cx_d = posx ? CMAX : (negx ? CMIN : sumx[OUT_W-1:0]);
  assign cy_d = posy ? CMAX : (negy ? CMIN : sumy[OUT_W-1:0]);

  always_ff @(posedge clk_i) begin
    if (ld_b) begin
      cx_q      <= cx_d;
      cy_q      <= cy_d;
      satc_q    <= posx || negx || posy || negy;
      x1_b_q    <= x1_a_q;
      y1_b_q    <= y1_a_q;
      degen_b_q <= degen_a_q;
    end
  end

  // C: corner minus reported center
  logic signed [DLT_W-1:0] dx_q, dy_q;
  logic signed [OUT_W-1:0] cx_c_q, cy_c_q;
  logic                    satc_c_q, degen_c_q;

  always_ff @(posedge clk_i) begin
    if (ld_c) begin
      dx_q      <= DLT_W'(x1_b_q) - DLT_W'(cx_q);
      dy_q      <= DLT_W'(y1_b_q) - DLT_W'(cy_q);
      cx_c_q    <= cx_q;
      cy_c_q    <= cy_q;
      satc_c_q  <= satc_q;
      degen_c_q <= degen_b_q;
    end
  end

  // D: squares (|delta| < 2^32, so each square fits 64 bits)
  logic signed [2*DLT_W-1:0] sqx_full, sqy_full;
  logic [SQ_W-1:0]           sqx_q, sqy_q;
  logic signed [OUT_W-1:0]   cx_d_q, cy_d_q;
  logic                      satc_d_q, degen_d_q;

  assign sqx_full = dx_q * dx_q;
  assign sqy_full = dy_q * dy_q;

  always_ff @(posedge clk_i) begin
    if (ld_d) begin
      sqx_q     <= sqx_full[SQ_W-1:0];
      sqy_q     <= sqy_full[SQ_W-1:0];
      cx_d_q    <= cx_c_q;
      cy_d_q    <= cy_c_q;
      satc_d_q  <= satc_c_q;
      degen_d_q <= degen_c_q;
    end
  end

  // E: radius sum with saturation; collinear corners force zeros
  logic [SQ_W:0]           r2_d;
  logic                    rsat_d;
  logic signed [OUT_W-1:0] cx_e_q, cy_e_q;
  logic [RAD_W-1:0]        rad_e_q;
  logic                    degen_e_q, sat_e_q;

  assign r2_d   = (SQ_W+1)'(sqx_q) + (SQ_W+1)'(sqy_q);
  assign rsat_d = |r2_d[SQ_W:RAD_W];

  always_ff @(posedge clk_i) begin
    if (ld_e) begin
      if (degen_d_q) begin
        cx_e_q  <= '0;
        cy_e_q  <= '0;
        rad_e_q <= '0;
        sat_e_q <= 1'b0;
      end else begin
        cx_e_q  <= cx_d_q;
        cy_e_q  <= cy_d_q;
        rad_e_q <= rsat_d ? {RAD_W{1'b1}} : r2_d[RAD_W-1:0];
        sat_e_q <= satc_d_q || rsat_d;
      end
      degen_e_q <= degen_d_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_a_q <= 1'b0;
      v_b_q <= 1'b0;
      v_c_q <= 1'b0;
      v_d_q <= 1'b0;
      v_e_q <= 1'b0;
    end else begin
      if (ld_a) v_a_q <= dv_valid;
      if (ld_b) v_b_q <= v_a_q;
      if (ld_c) v_c_q <= v_b_q;
      if (ld_d) v_d_q <= v_c_q;
      if (ld_e) v_e_q <= v_d_q;
    end
  end

  assign out_valid_o      = v_e_q;
  assign center_x_o       = cx_e_q;
  assign center_y_o       = cy_e_q;
  assign radius_squared_o = rad_e_q;
  assign degenerate_o     = degen_e_q;
  assign saturated_o      = sat_e_q;

`ifndef SYNTHESIS
  // the two dividers must never drift apart
  a_div_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dvx_valid == dvy_valid)
    else $error("divider valid bits out of step");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |-> center_x_o == '0 && center_y_o == '0 &&
      radius_squared_o == '0 && !saturated_o)
    else $error("collinear result not cleared");

  a_sat_clipped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |-> center_x_o == CMAX || center_x_o == CMIN ||
      center_y_o == CMAX || center_y_o == CMIN || radius_squared_o == {RAD_W{1'b1}})
    else $error("saturated flag without clipped value");
`endif

endmodule
